FILE: hdl/pst_pkg.sv
// ============================================================================
// pst_pkg
// Shared types, constants and round functions for the PRESENT-80 encrypt
// pipeline.
// ============================================================================
package pst_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 80;
    localparam int KEY_HI_W = 16;
    localparam int RC_W    = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    // Data handed from one round cell to the next
    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] state;
        logic [KEY_W-1:0]   key;
    } pst_link_t;

    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] k);
        return k[KEY_W-1:KEY_W-BLOCK_W];
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    // bit i moves to 16*i mod 63, bit 63 stays
    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < 63; i++)
        begin
            r[(16 * i) % 63] = s[i];
        end
        r[63] = s[63];
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                   input logic [RC_W-1:0] rc);
        logic [KEY_W-1:0] r;
        r = {k[18:0], k[79:19]};
        r[79:76] = SBOX[r[79:76]];
        r[19:15] = r[19:15] ^ rc;
        return r;
    endfunction

endpackage

FILE: hdl/pst_round_cell.sv
// ============================================================================
// pst_round_cell
// One PRESENT round: key add, S-box layer, pLayer and key schedule step,
// registered and handed to the next cell.
// ============================================================================
module pst_round_cell
    import pst_pkg::*;
#(
    parameter int ROUND_NUM = 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pst_link_t link_in,
    output pst_link_t link_out
);

    localparam logic [RC_W-1:0] RC = RC_W'(ROUND_NUM);

    logic               valid_reg;
    logic [BLOCK_W-1:0] state_reg;
    logic [BLOCK_W-1:0] state_next;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;

    always_comb
    begin
        state_next = perm_layer(sub_layer(link_in.state ^ round_key(link_in.key)));
        key_next   = key_update(link_in.key, RC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign link_out = '{valid: valid_reg, state: state_reg, key: key_reg};

endmodule

FILE: hdl/present80_block_encrypt.sv
// ============================================================================
// present80_block_encrypt
// PRESENT-80 block encryption as a chain of round cells, one block per cycle.
// ============================================================================
// Usage:
//   Key: write key_low (index 0, 64 bits) and key_high (index 1, low 16 bits
//   kept) through cfg_wr_en / cfg_index / cfg_wdata while no item is in
//   flight. Both reset to zero.
//   Input: an item is taken at each rising edge with start high and busy
//   low. busy stays low, so a new plaintext can enter every cycle.
//   Output: ciphertext is valid for one cycle while done is high.
//   Pipeline: from accept to done an item passes one register per round
//   cell plus the output register holding the final key add.
//   Throughput: one item per cycle; each round cell carries its own copy of
//   the key schedule along with the block.
//   Reset: clears the key registers and all valid flags; items in flight
//   are dropped. The receiver cannot stall, so results are never held.
// ============================================================================
module present80_block_encrypt
    import pst_pkg::*;
#(
    parameter int ROUND_COUNT = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [BLOCK_W-1:0]     plaintext,
    output logic                   done,
    output logic [BLOCK_W-1:0]     ciphertext,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [BLOCK_W-1:0]  key_low_reg;
    logic [KEY_HI_W-1:0] key_high_reg;
    logic                done_reg;
    logic [BLOCK_W-1:0]  ciphertext_reg;
    logic [BLOCK_W-1:0]  ciphertext_next;

    pst_link_t chain [ROUND_COUNT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                REG_KEY_HIGH: key_high_reg <= cfg_wdata[KEY_HI_W-1:0];
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    assign chain[0] = '{valid: start & ~busy, state: plaintext,
                        key: {key_high_reg, key_low_reg}};

    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        pst_round_cell #(
            .ROUND_NUM (g + 1)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (chain[g]),
            .link_out (chain[g+1])
        );
    end

    // final key add
    assign ciphertext_next = chain[ROUND_COUNT].state ^ round_key(chain[ROUND_COUNT].key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain[ROUND_COUNT].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ciphertext_reg <= ciphertext_next;
    end

    assign done       = done_reg;
    assign ciphertext = ciphertext_reg;

endmodule
